>>> hw/rtl/sobm_pkg.sv
// Shared types, constants and the Sobel kernel function for the edge magnitude block.
`timescale 1ns / 1ps

package sobm_pkg;

  localparam int PIX_W       = 8;
  localparam int COLW_W      = 3 * PIX_W;   // top, middle, bottom sample of one column
  localparam int OUT_COL_W   = 11;
  localparam int WIDTH_CFG_W = 12;
  localparam int OUT_DATA_W  = 24;
  localparam int MAG_MAX     = 255;

  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 12'd640;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef logic [COLW_W-1:0] column_t;

  // |Gx| + |Gy| over columns l, cc, r (each {top, mid, bot}), saturated.
  function automatic logic [PIX_W-1:0] edge_mag(input column_t l, input column_t cc,
                                                input column_t r);
    logic [9:0]  sum_l;
    logic [9:0]  sum_r;
    logic [9:0]  sum_t;
    logic [9:0]  sum_b;
    logic [10:0] gx;
    logic [10:0] gy;
    logic [10:0] ax;
    logic [10:0] ay;
    logic [11:0] mag;
    sum_l = {2'b00, l[23:16]} + {1'b0, l[15:8], 1'b0} + {2'b00, l[7:0]};
    sum_r = {2'b00, r[23:16]} + {1'b0, r[15:8], 1'b0} + {2'b00, r[7:0]};
    sum_t = {2'b00, l[23:16]} + {1'b0, cc[23:16], 1'b0} + {2'b00, r[23:16]};
    sum_b = {2'b00, l[7:0]} + {1'b0, cc[7:0], 1'b0} + {2'b00, r[7:0]};
    gx = {1'b0, sum_r} - {1'b0, sum_l};
    gy = {1'b0, sum_b} - {1'b0, sum_t};
    ax = gx[10] ? (11'd0 - gx) : gx;
    ay = gy[10] ? (11'd0 - gy) : gy;
    mag = {1'b0, ax} + {1'b0, ay};
    return (mag > 12'(MAG_MAX)) ? PIX_W'(MAG_MAX) : mag[PIX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/sobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/sobel_edge_magnitude_3x3.sv
// Top level: streaming 3x3 Sobel edge magnitude with two line-store RAMs.
//
//  channel | dir | handshake              | content
//  --------+-----+------------------------+--------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready  | image_width (12 bits)
//  in      | in  | in_tvalid / in_tready  | pixel_value in tdata, opcode in tuser
//  out     | out | out_tvalid / out_tready| magnitude, out_column; tlast, tuser
//
// One word per cycle is accepted unless the output stalls or two results are pending; the
// read of both line stores happens at accept, the read-modify-write completes when the word
// leaves stage 1, with forwarding for a repeat of the same column. The last word of a row
// yields two results when W is two or more, which leave the output register one after the
// other while input is held off; the first row of a frame gives no results.
// A word passes stage 1 and stage 2 before its result is loaded into the output register.
// Reset clears all control state; line-store contents stay undefined until written.
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sobm_pkg::WIDTH_CFG_W-1:0]    cfg_data,   // image_width
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sobm_pkg::PIX_W-1:0]          in_tdata,   // [7:0] pixel_value
  input  logic                                in_tuser,   // [0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sobm_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] magnitude, [18:8] out_column
  output logic                                out_tlast,  // last_of_run
  output logic                                out_tuser   // [0] end_of_frame
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > sobm_pkg::WIDTH_CFG_W) ? CW + 1 : sobm_pkg::WIDTH_CFG_W;
  localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
  localparam int PW   = sobm_pkg::PIX_W;

  // configuration
  logic [sobm_pkg::WIDTH_CFG_W-1:0] width_r;
  logic [CMPW-1:0]                  width_ext;
  logic [CMPW-1:0]                  width_eff;

  // stage 0: column / row tracking
  logic [CW-1:0] col_cnt_r;
  logic          phase_r;
  logic          in_accept;
  logic          row_end;
  logic          is_drain;

  // stage 1: item waiting on line-store data
  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_end_r;
  logic          s1_phase_r;
  logic          s1_drain_r;
  logic [PW-1:0] s1_pix_r;
  logic          s1_move;

  logic          fwd_r;
  logic [PW-1:0] fwd_top_r;
  logic [PW-1:0] fwd_mid_r;
  logic [PW-1:0] ram_top;
  logic [PW-1:0] ram_mid;
  logic [PW-1:0] top;
  logic [PW-1:0] mid;

  sobm_pkg::column_t win0_r;
  sobm_pkg::column_t win1_r;
  sobm_pkg::column_t win2_r;

  // stage 2: pending results
  logic          s2_a_r;
  logic          s2_b_r;
  logic [CW-1:0] s2_col_r;
  logic          s2_eof_r;
  logic          s2_done;
  logic          out_load;
  logic [PW-1:0] mag_a;
  logic [PW-1:0] mag_b;
  logic [CMPW-1:0] col_a_ext;
  logic [CMPW-1:0] col_b_ext;

  // output register
  logic                              out_valid_r;
  logic [PW-1:0]                     out_mag_r;
  logic [sobm_pkg::OUT_COL_W-1:0]    out_col_r;
  logic                              out_last_r;
  logic                              out_eof_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= sobm_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  assign width_ext = CMPW'(width_r);
  assign width_eff = (width_ext == '0)    ? CMPW'(1) :
                     (width_ext > MAXW_C) ? MAXW_C   : width_ext;

  // ---------------- stage 0 ----------------
  assign in_tready = !s1_valid_r || s1_move;
  assign in_accept = in_tvalid && in_tready;
  assign is_drain  = (sobm_pkg::opcode_t'(in_tuser) == sobm_pkg::OP_DRAIN);
  assign row_end   = ({{(CMPW-CW){1'b0}}, col_cnt_r} + CMPW'(1)) >= width_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      phase_r   <= 1'b0;
    end else if (in_accept) begin
      col_cnt_r <= row_end ? '0 : col_cnt_r + CW'(1);
      if (row_end) begin
        phase_r <= !is_drain;
      end
    end
  end

  // ---------------- line stores ----------------
  sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_two_above (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (mid),
    .re    (in_accept),
    .raddr (col_cnt_r),
    .rdata (ram_top)
  );

  sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (in_accept),
    .raddr (col_cnt_r),
    .rdata (ram_mid)
  );

  // ---------------- stage 1 ----------------
  assign s1_move = s1_valid_r && s2_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      // a write landing on the address being read returns stale data: bypass it
      if (in_accept) begin
        fwd_r <= s1_move && (s1_col_r == col_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r   <= col_cnt_r;
      s1_end_r   <= row_end;
      s1_phase_r <= phase_r;
      s1_drain_r <= is_drain;
      s1_pix_r   <= is_drain ? '0 : in_tdata;
      fwd_top_r  <= mid;
      fwd_mid_r  <= s1_pix_r;
    end
  end

  assign top = s1_phase_r ? (fwd_r ? fwd_top_r : ram_top) : '0;
  assign mid = s1_phase_r ? (fwd_r ? fwd_mid_r : ram_mid) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
    end else if (s1_move) begin
      win0_r <= (s1_col_r == '0) ? '0 : win1_r;
      win1_r <= (s1_col_r == '0) ? '0 : win2_r;
      win2_r <= {top, mid, s1_pix_r};
    end
  end

  // ---------------- stage 2 ----------------
  assign out_load = (!out_valid_r || out_tready) && (s2_a_r || s2_b_r);
  assign s2_done  = !(s2_a_r || s2_b_r) || (out_load && !(s2_a_r && s2_b_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_a_r <= 1'b0;
      s2_b_r <= 1'b0;
    end else if (s1_move) begin
      s2_a_r <= s1_phase_r && (s1_col_r != '0);
      s2_b_r <= s1_phase_r && s1_end_r;
    end else if (out_load) begin
      // drain the column result first, then the row-end result
      if (s2_a_r) begin
        s2_a_r <= 1'b0;
      end else begin
        s2_b_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_col_r <= s1_col_r;
      s2_eof_r <= s1_end_r && s1_drain_r;
    end
  end

  // window is stable while results are pending
  assign mag_a     = sobm_pkg::edge_mag(win0_r, win1_r, win2_r);
  assign mag_b     = sobm_pkg::edge_mag(win1_r, win2_r, '0);
  assign col_a_ext = CMPW'(s2_col_r - CW'(1));
  assign col_b_ext = CMPW'(s2_col_r);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s2_a_r) begin
        out_mag_r  <= mag_a;
        out_col_r  <= col_a_ext[sobm_pkg::OUT_COL_W-1:0];
        out_last_r <= !s2_b_r;
        out_eof_r  <= 1'b0;
      end else begin
        out_mag_r  <= mag_b;
        out_col_r  <= col_b_ext[sobm_pkg::OUT_COL_W-1:0];
        out_last_r <= 1'b1;
        out_eof_r  <= s2_eof_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sobm_pkg::OUT_DATA_W - sobm_pkg::OUT_COL_W - PW){1'b0}},
                       out_col_r, out_mag_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_eof_r;

  // ---------------- assertions ----------------
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eof_r |-> out_last_r)
    else $error("end of frame on a result that is not last of its word");

  a_row_end_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> s2_b_r)
    else $error("non-last result shown without a row-end result pending");

  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && s2_a_r && s2_b_r |=> s2_b_r && !s2_a_r)
    else $error("row-end result lost while emitting the column result");

  a_stall_blocks_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_done |=> s1_valid_r && $stable(s1_col_r))
    else $error("stage 1 item dropped while results were pending");

endmodule

>>> tb/sobel_edge_magnitude_3x3_tb.sv
// Self-checking testbench for the streaming 3x3 Sobel edge magnitude block.
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3_tb;

  localparam int LINE_DEPTH   = 2048;
  localparam int SETTLE_WAIT  = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [sobm_pkg::PIX_W-1:0]     magnitude;
    logic [sobm_pkg::OUT_COL_W-1:0] column;
    logic                           last_of_run;
    logic                           end_of_frame;
  } edge_word_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [sobm_pkg::WIDTH_CFG_W-1:0] cfg_data = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [sobm_pkg::PIX_W-1:0]       in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [sobm_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                             out_tlast;
  logic                             out_tuser;

  sobel_edge_magnitude_3x3 #(.MAX_WIDTH(LINE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted image state
  logic [sobm_pkg::WIDTH_CFG_W-1:0] width_cfg = sobm_pkg::WIDTH_RESET;
  logic [sobm_pkg::PIX_W-1:0]       line_above     [LINE_DEPTH];
  logic [sobm_pkg::PIX_W-1:0]       line_two_above [LINE_DEPTH];
  int unsigned                      col_count = 0;
  logic                             in_later_row = 1'b0;
  sobm_pkg::column_t                win_cols [3] = '{default: '0};

  edge_word_t due_edges [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_seq = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  function automatic int row_length(input logic [sobm_pkg::WIDTH_CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic logic [sobm_pkg::PIX_W-1:0] gradient_sum(input sobm_pkg::column_t l,
                                                              input sobm_pkg::column_t m,
                                                              input sobm_pkg::column_t r);
    int gx;
    int gy;
    int s;
    gx = (int'(r[23:16]) + 2 * int'(r[15:8]) + int'(r[7:0]))
       - (int'(l[23:16]) + 2 * int'(l[15:8]) + int'(l[7:0]));
    gy = (int'(l[7:0]) + 2 * int'(m[7:0]) + int'(r[7:0]))
       - (int'(l[23:16]) + 2 * int'(m[23:16]) + int'(r[23:16]));
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    s = gx + gy;
    if (s > sobm_pkg::MAG_MAX) s = sobm_pkg::MAG_MAX;
    return sobm_pkg::PIX_W'(s);
  endfunction

  function automatic void predict_edges(input sobm_pkg::opcode_t op,
                                        input logic [sobm_pkg::PIX_W-1:0] sample);
    logic [sobm_pkg::PIX_W-1:0] pix;
    logic [sobm_pkg::PIX_W-1:0] top;
    logic [sobm_pkg::PIX_W-1:0] mid;
    int unsigned                w;
    int unsigned                c;
    int unsigned                idx;
    logic                       row_end;
    logic                       drain;
    edge_word_t                 word;
    drain = (op == sobm_pkg::OP_DRAIN);
    pix = drain ? '0 : sample;
    w = row_length(width_cfg);
    c = col_count;
    idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
    row_end = (c + 1 >= w);
    top = '0;
    mid = '0;
    if (in_later_row) begin
      top = line_two_above[idx];
      mid = line_above[idx];
      line_two_above[idx] = mid;
    end else begin
      line_two_above[idx] = '0;  // top padding
    end
    line_above[idx] = pix;
    if (c == 0) win_cols = '{default: '0};
    win_cols[0] = win_cols[1];
    win_cols[1] = win_cols[2];
    win_cols[2] = {top, mid, pix};
    if (in_later_row) begin
      if (c >= 1) begin
        word.magnitude    = gradient_sum(win_cols[0], win_cols[1], win_cols[2]);
        word.column       = sobm_pkg::OUT_COL_W'(c - 1);
        word.last_of_run  = !row_end;
        word.end_of_frame = 1'b0;
        due_edges.push_back(word);
      end
      if (row_end) begin
        // right padding column closes the row
        word.magnitude    = gradient_sum(win_cols[1], win_cols[2], '0);
        word.column       = sobm_pkg::OUT_COL_W'(c);
        word.last_of_run  = 1'b1;
        word.end_of_frame = drain;
        due_edges.push_back(word);
      end
    end
    if (row_end) begin
      col_count = 0;
      in_later_row = !drain;
    end else begin
      col_count = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      predict_edges(sobm_pkg::opcode_t'(in_tuser), in_tdata);
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    edge_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_edges.size() == 0) begin
        flag_mismatch($sformatf("unexpected word, column %0d", out_tdata[18:8]));
      end else begin
        want = due_edges.pop_front();
        if (out_tdata[7:0] != want.magnitude)
          flag_mismatch($sformatf("column %0d: magnitude %0d, want %0d", want.column,
                                  out_tdata[7:0], want.magnitude));
        if (out_tdata[18:8] != want.column)
          flag_mismatch($sformatf("column %0d, want %0d", out_tdata[18:8], want.column));
        if (out_tlast != want.last_of_run)
          flag_mismatch($sformatf("column %0d: tlast %0b, want %0b", want.column,
                                  out_tlast, want.last_of_run));
        if (out_tuser != want.end_of_frame)
          flag_mismatch($sformatf("column %0d: end of frame %0b, want %0b", want.column,
                                  out_tuser, want.end_of_frame));
      end
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input sobm_pkg::opcode_t op, input logic [sobm_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted word is out and the pipe is empty.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_width(input logic [sobm_pkg::WIDTH_CFG_W-1:0] w);
    settle_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_cfg = w;
  endtask

  function automatic logic [sobm_pkg::PIX_W-1:0] pick_pixel(input int style,
                                                            input logic [sobm_pkg::PIX_W-1:0] base);
    int v;
    case (style)
      0: return sobm_pkg::PIX_W'($urandom_range(255));
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: begin
        v = int'(base) + int'($urandom_range(12)) - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return sobm_pkg::PIX_W'(v);
      end
    endcase
  endfunction

  task automatic send_row(input sobm_pkg::opcode_t op, input int cols);
    repeat (cols) send_item(op, sobm_pkg::PIX_W'($urandom));
  endtask

  // Drain row as first row, extremes, drain mixed into an image row.
  task automatic test_padding_and_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_width(12'd3);
    send_row(sobm_pkg::OP_DRAIN, 3);
    send_item(sobm_pkg::OP_PIXEL, 8'h00);
    send_item(sobm_pkg::OP_PIXEL, 8'hFF);
    send_item(sobm_pkg::OP_PIXEL, 8'h00);
    send_item(sobm_pkg::OP_PIXEL, 8'hFF);
    send_item(sobm_pkg::OP_DRAIN, 8'h5A);
    send_item(sobm_pkg::OP_PIXEL, 8'hFF);
    send_row(sobm_pkg::OP_DRAIN, 3);
  endtask

  // Width 0 is taken as one column; every word ends a row.
  task automatic test_width_zero();
    write_width(12'd0);
    send_item(sobm_pkg::OP_PIXEL, 8'hFF);
    send_item(sobm_pkg::OP_PIXEL, 8'h11);
    send_item(sobm_pkg::OP_DRAIN, 8'hAA);
  endtask

  // Lower the width while a row is half done: the next word ends that row.
  task automatic test_width_lowered_mid_row();
    write_width(12'd6);
    send_item(sobm_pkg::OP_PIXEL, 8'h10);
    send_item(sobm_pkg::OP_PIXEL, 8'hF0);
    send_item(sobm_pkg::OP_PIXEL, 8'h80);
    send_item(sobm_pkg::OP_PIXEL, 8'h01);
    send_item(sobm_pkg::OP_PIXEL, 8'hFE);
    send_item(sobm_pkg::OP_PIXEL, 8'h7F);
    send_item(sobm_pkg::OP_PIXEL, 8'hC3);
    send_item(sobm_pkg::OP_PIXEL, 8'h3C);
    send_item(sobm_pkg::OP_PIXEL, 8'h00);
    send_item(sobm_pkg::OP_PIXEL, 8'hFF);
    write_width(12'd2);
    send_item(sobm_pkg::OP_PIXEL, 8'h55);
    send_row(sobm_pkg::OP_DRAIN, 2);
  endtask

  // Hold the output off while the sender keeps offering words.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_width(12'd64);
    hold_seq++;
    repeat (3) send_row(sobm_pkg::OP_PIXEL, 64);
    send_row(sobm_pkg::OP_DRAIN, 64);
  endtask

  task automatic test_random_frames(input int item_goal, input int send_pct, input int recv_pct);
    int                         sent;
    int                         rows;
    int                         style;
    int                         cols;
    logic [sobm_pkg::PIX_W-1:0] base;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < item_goal) begin
      if (sent == 0 || $urandom_range(2) == 0) begin
        case ($urandom_range(19))
          0:       write_width(12'd0);
          1, 2:    write_width(sobm_pkg::WIDTH_CFG_W'($urandom_range(13, 48)));
          default: write_width(sobm_pkg::WIDTH_CFG_W'($urandom_range(1, 10)));
        endcase
      end
      cols = row_length(width_cfg);
      style = $urandom_range(2);
      base = sobm_pkg::PIX_W'($urandom);
      if ($urandom_range(9) == 0) begin
        send_row(sobm_pkg::OP_DRAIN, cols);
        sent += cols;
      end
      rows = $urandom_range(1, 4);
      repeat (rows) begin
        for (int c = 0; c < cols; c++)
          send_item(($urandom_range(24) == 0) ? sobm_pkg::OP_DRAIN : sobm_pkg::OP_PIXEL,
                    pick_pixel(style, base));
        sent += cols;
      end
      send_row(sobm_pkg::OP_DRAIN, cols);
      sent += cols;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_padding_and_drain();
    test_width_zero();
    test_width_lowered_mid_row();
    test_backpressure();
    test_random_frames(280, 0, 0);
    test_random_frames(280, 81, 0);
    test_random_frames(280, 0, 81);
    test_random_frames(280, 30, 30);
    recv_stall_pct = 0;
    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sobm_pkg.sv
hw/rtl/sobm_ram.sv
hw/rtl/sobel_edge_magnitude_3x3.sv
tb/sobel_edge_magnitude_3x3_tb.sv
